// ----- rtl/core/gcib_pkg.sv -----
package gcib_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int DEG_180      = 180;

    // Widths of the fixed input and output words.
    localparam int LON_W = 25;
    localparam int LAT_W = 24;
    localparam int OUT_W = 25;
    // Angle difference and sign-extended latitudes share one width.
    localparam int ANG_W = 26;

    // Sine/cosine datapath: Q30 values and degrees * 2^32 angles.
    localparam int SC_W  = 32;
    localparam int SCZ_W = 41;
    // Vectoring datapath.
    localparam int VEC_W = 35;
    localparam int VZ_W  = 42;

    // CORDIC gain compensation in Q30.
    localparam logic signed [SC_W-1:0] GAIN_Q30 = 32'sd652032874;

    // atan(2^-i) in degrees * 2^32.
    localparam logic [63:0] ATAN_TAB [CORDIC_STEPS] = '{
        64'd193273528320, 64'd114096026022, 64'd60285206653, 64'd30601712204,
        64'd15360239181,  64'd7687607525,   64'd3844741809,  64'd1922488225,
        64'd961258780,    64'd480631223,    64'd240315841,   64'd120157949,
        64'd60078978,     64'd30039489,     64'd15019745,    64'd7509872,
        64'd3754936,      64'd1877468,      64'd938734,      64'd469367,
        64'd234684,       64'd117342,       64'd58671,       64'd29335,
        64'd14668,        64'd7334,         64'd3667,        64'd1833
    };

    // Number of conditional-subtract stages that bring any angle difference
    // below one full turn.
    function automatic int red_steps(input int frac_bits);
        red_steps = (frac_bits < 18) ? (18 - frac_bits) : 0;
    endfunction

    // Sideband that travels with each word down the pipeline.
    typedef struct packed {
        logic vld;
        logic same;
    } t_side;

endpackage

// ----- rtl/core/gcib_sincos.sv -----
module gcib_sincos #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic signed [gcib_pkg::ANG_W-1:0]  i_angle,
    output logic signed [gcib_pkg::SC_W-1:0]   o_sin,
    output logic signed [gcib_pkg::SC_W-1:0]   o_cos
);
    import gcib_pkg::*;

    localparam int RED = red_steps(ANGLE_FRAC_BITS);
    localparam int SH  = 32 - ANGLE_FRAC_BITS;
    localparam logic [63:0] MOD  = 64'(360) << ANGLE_FRAC_BITS;
    localparam logic [63:0] HALF = 64'(DEG_180) << ANGLE_FRAC_BITS;
    localparam logic [63:0] QTR  = 64'(90) << ANGLE_FRAC_BITS;

    logic [ANG_W-1:0]        r_mag [0:RED];
    logic                    r_sgn [0:RED];
    logic signed [SC_W-1:0]  r_x   [0:CORDIC_STEPS];
    logic signed [SC_W-1:0]  r_y   [0:CORDIC_STEPS];
    logic signed [SCZ_W-1:0] r_z   [0:CORDIC_STEPS];
    logic                    r_neg [0:CORDIC_STEPS];

    // Magnitude and sign, so that the remainder follows the dividend's sign.
    always_ff @(posedge i_clk) begin
        r_sgn[0] <= i_angle[ANG_W-1];
        r_mag[0] <= i_angle[ANG_W-1] ? ANG_W'(-i_angle) : ANG_W'(i_angle);
    end

    // Restoring reduction modulo one turn, one multiple of the turn a stage.
    for (genvar j = 1; j <= RED; j++) begin : g_red
        localparam logic [63:0] SUB = MOD << (RED - j);
        always_ff @(posedge i_clk) begin
            r_sgn[j] <= r_sgn[j-1];
            if (64'(r_mag[j-1]) >= SUB) begin
                r_mag[j] <= ANG_W'(64'(r_mag[j-1]) - SUB);
            end else begin
                r_mag[j] <= r_mag[j-1];
            end
        end
    end

    // Wrap into (-180, 180], then fold into [-90, 90] with a sign flip.
    logic signed [SCZ_W-1:0] n_a0, n_a1, n_a2;
    logic                    n_neg;
    always_comb begin
        n_a0  = r_sgn[RED] ? -SCZ_W'(r_mag[RED]) : SCZ_W'(r_mag[RED]);
        n_a1  = n_a0;
        if (n_a0 > $signed(SCZ_W'(HALF))) begin
            n_a1 = n_a0 - $signed(SCZ_W'(MOD));
        end else if (n_a0 <= -$signed(SCZ_W'(HALF))) begin
            n_a1 = n_a0 + $signed(SCZ_W'(MOD));
        end
        n_a2  = n_a1;
        n_neg = 1'b0;
        if (n_a1 > $signed(SCZ_W'(QTR))) begin
            n_a2  = n_a1 - $signed(SCZ_W'(HALF));
            n_neg = 1'b1;
        end else if (n_a1 < -$signed(SCZ_W'(QTR))) begin
            n_a2  = n_a1 + $signed(SCZ_W'(HALF));
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]   <= GAIN_Q30;
        r_y[0]   <= '0;
        r_z[0]   <= n_a2 <<< SH;
        r_neg[0] <= n_neg;
    end

    // Rotation-mode CORDIC, one micro-rotation a stage.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        logic signed [SC_W-1:0] n_dx, n_dy;
        assign n_dx = r_y[i] >>> i;
        assign n_dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            r_neg[i+1] <= r_neg[i];
            if (r_z[i] >= 0) begin
                r_x[i+1] <= r_x[i] - n_dx;
                r_y[i+1] <= r_y[i] + n_dy;
                r_z[i+1] <= r_z[i] - $signed(SCZ_W'(ATAN_TAB[i]));
            end else begin
                r_x[i+1] <= r_x[i] + n_dx;
                r_y[i+1] <= r_y[i] - n_dy;
                r_z[i+1] <= r_z[i] + $signed(SCZ_W'(ATAN_TAB[i]));
            end
        end
    end

    logic unused_z;
    assign unused_z = ^r_z[CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        o_sin <= r_neg[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        o_cos <= r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
    end

endmodule

// ----- rtl/core/gcib_atan2.sv -----
module gcib_atan2 #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic signed [gcib_pkg::SC_W-1:0]   i_east,
    input  logic signed [gcib_pkg::SC_W:0]     i_north,
    output logic signed [gcib_pkg::OUT_W-1:0]  o_angle
);
    import gcib_pkg::*;

    localparam int SH = 32 - ANGLE_FRAC_BITS;
    localparam logic [63:0] HALF_Q32 = 64'(DEG_180) << 32;
    localparam logic [63:0] LIM      = 64'(DEG_180) << ANGLE_FRAC_BITS;
    localparam int RW = VZ_W + 1;

    logic signed [VEC_W-1:0] r_e    [0:CORDIC_STEPS];
    logic signed [VEC_W-1:0] r_n    [0:CORDIC_STEPS];
    logic signed [VZ_W-1:0]  r_z    [0:CORDIC_STEPS];
    logic                    r_zero [0:CORDIC_STEPS];

    // A vector in the southern half plane is turned by half a turn first.
    always_ff @(posedge i_clk) begin
        r_zero[0] <= (i_east == 0) && (i_north == 0);
        if (i_north < 0) begin
            r_e[0] <= -VEC_W'(i_east);
            r_n[0] <= -VEC_W'(i_north);
            r_z[0] <= (i_east >= 0) ? $signed(VZ_W'(HALF_Q32)) : -$signed(VZ_W'(HALF_Q32));
        end else begin
            r_e[0] <= VEC_W'(i_east);
            r_n[0] <= VEC_W'(i_north);
            r_z[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
        logic signed [VEC_W-1:0] n_dn, n_de;
        assign n_dn = r_e[i] >>> i;
        assign n_de = r_n[i] >>> i;
        always_ff @(posedge i_clk) begin
            r_zero[i+1] <= r_zero[i];
            if (r_e[i] > 0) begin
                r_n[i+1] <= r_n[i] + n_dn;
                r_e[i+1] <= r_e[i] - n_de;
                r_z[i+1] <= r_z[i] + $signed(VZ_W'(ATAN_TAB[i]));
            end else begin
                r_n[i+1] <= r_n[i] - n_dn;
                r_e[i+1] <= r_e[i] + n_de;
                r_z[i+1] <= r_z[i] - $signed(VZ_W'(ATAN_TAB[i]));
            end
        end
    end

    logic unused_vec;
    assign unused_vec = ^{r_e[CORDIC_STEPS], r_n[CORDIC_STEPS]};

    // Round half up to the output grid and clamp to +-180 degrees.
    logic signed [RW-1:0] n_sum, n_r, n_c;
    always_comb begin
        n_sum = RW'(r_z[CORDIC_STEPS]) + $signed(RW'(64'd1 << (SH - 1)));
        n_r   = n_sum >>> SH;
        n_c   = n_r;
        if (n_r > $signed(RW'(LIM))) begin
            n_c = $signed(RW'(LIM));
        end else if (n_r < -$signed(RW'(LIM))) begin
            n_c = -$signed(RW'(LIM));
        end
    end

    always_ff @(posedge i_clk) begin
        o_angle <= r_zero[CORDIC_STEPS] ? '0 : n_c[OUT_W-1:0];
    end

endmodule

// ----- rtl/core/great_circle_initial_bearing_top.sv -----
// A word accepted with start shows its bearing on o_bearing_degrees with o_valid
// after the full pipeline depth, which grows with red_steps(F), F = ANGLE_FRAC_BITS.
// Throughput: one word per clock; busy never rises and every stage is a register.
// The depth is set by the two 28-step CORDIC chains, the angle reduction, the
// product stages and the input and output registers. Reset (synchronous, active low)
// clears only the valid bits and sideband flags; the receiver cannot stall the output strobe.
module great_circle_initial_bearing_top #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [gcib_pkg::LON_W-1:0]   i_start_longitude,
    input  logic signed [gcib_pkg::LAT_W-1:0]   i_start_latitude,
    input  logic signed [gcib_pkg::LON_W-1:0]   i_end_longitude,
    input  logic signed [gcib_pkg::LAT_W-1:0]   i_end_latitude,
    output logic                                o_valid,
    output logic signed [gcib_pkg::OUT_W-1:0]   o_bearing_degrees
);
    import gcib_pkg::*;

    // Stage counts: sine/cosine unit, three product stages, vectoring unit.
    localparam int SC_LAT = red_steps(ANGLE_FRAC_BITS) + CORDIC_STEPS + 3;
    localparam int AT_LAT = CORDIC_STEPS + 2;
    localparam int SIDE_N = SC_LAT + 3 + AT_LAT;
    localparam logic [63:0] LIM = 64'(DEG_180) << ANGLE_FRAC_BITS;

    // Every stage accepts a new word each cycle, so the block is never busy.
    assign busy = 1'b0;

    // Input registers. Only the valid bit needs a reset.
    logic                    r_v0;
    logic signed [LON_W-1:0] r_lon1, r_lon2;
    logic signed [LAT_W-1:0] r_lat1, r_lat2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lon1 <= i_start_longitude;
        r_lat1 <= i_start_latitude;
        r_lon2 <= i_end_longitude;
        r_lat2 <= i_end_latitude;
    end

    // Longitude difference and sign-extended latitudes feed three identical
    // sine/cosine pipelines that stay in lock step.
    logic signed [ANG_W-1:0] n_dlon, n_lat1, n_lat2;
    logic                    n_same;
    assign n_dlon = ANG_W'(r_lon2) - ANG_W'(r_lon1);
    assign n_lat1 = ANG_W'(r_lat1);
    assign n_lat2 = ANG_W'(r_lat2);
    assign n_same = (r_lon1 == r_lon2) && (r_lat1 == r_lat2);

    logic signed [SC_W-1:0] w_s_dl, w_c_dl, w_s_l1, w_c_l1, w_s_l2, w_c_l2;

    gcib_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_dlon (
        .i_clk   (i_clk),
        .i_angle (n_dlon),
        .o_sin   (w_s_dl),
        .o_cos   (w_c_dl)
    );

    gcib_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_lat1 (
        .i_clk   (i_clk),
        .i_angle (n_lat1),
        .o_sin   (w_s_l1),
        .o_cos   (w_c_l1)
    );

    gcib_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_lat2 (
        .i_clk   (i_clk),
        .i_angle (n_lat2),
        .o_sin   (w_s_l2),
        .o_cos   (w_c_l2)
    );

    // First product stage: east, cos(lat1)*sin(lat2), sin(lat1)*cos(lat2).
    // Each Q30 product is floored back to Q30 by the arithmetic shift.
    logic signed [2*SC_W-1:0] n_pe, n_p1, n_p2, n_p3;
    logic signed [SC_W-1:0]   r_m1_east, r_m1_p1, r_m1_p2, r_m1_cdl;
    logic signed [SC_W-1:0]   r_m2_east, r_m2_p1, r_m2_p3;
    logic signed [SC_W-1:0]   r_m3_east;
    logic signed [SC_W:0]     r_m3_north;

    assign n_pe = (2*SC_W)'(w_s_dl) * (2*SC_W)'(w_c_l2);
    assign n_p1 = (2*SC_W)'(w_c_l1) * (2*SC_W)'(w_s_l2);
    assign n_p2 = (2*SC_W)'(w_s_l1) * (2*SC_W)'(w_c_l2);
    assign n_p3 = (2*SC_W)'(r_m1_p2) * (2*SC_W)'(r_m1_cdl);

    always_ff @(posedge i_clk) begin
        r_m1_east  <= SC_W'(n_pe >>> 30);
        r_m1_p1    <= SC_W'(n_p1 >>> 30);
        r_m1_p2    <= SC_W'(n_p2 >>> 30);
        r_m1_cdl   <= w_c_dl;
        // Second stage: the remaining product with cos(dlon).
        r_m2_east  <= r_m1_east;
        r_m2_p1    <= r_m1_p1;
        r_m2_p3    <= SC_W'(n_p3 >>> 30);
        // Third stage: the north component.
        r_m3_east  <= r_m2_east;
        r_m3_north <= (SC_W+1)'(r_m2_p1) - (SC_W+1)'(r_m2_p3);
    end

    logic signed [OUT_W-1:0] w_angle;

    gcib_atan2 #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_atan2 (
        .i_clk   (i_clk),
        .i_east  (r_m3_east),
        .i_north (r_m3_north),
        .o_angle (w_angle)
    );

    // Valid bit and the coinciding-points flag ride alongside the datapath.
    t_side r_side [0:SIDE_N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SIDE_N; k++) begin
                r_side[k] <= '0;
            end
        end else begin
            r_side[0] <= '{vld: r_v0, same: n_same};
            for (int k = 1; k < SIDE_N; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Output register: coinciding points give a bearing of zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_side[SIDE_N-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_bearing_degrees <= r_side[SIDE_N-1].same ? '0 : w_angle;
    end

    // Every accepted word comes out exactly after the full pipeline depth.
    a_start_to_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(SIDE_N + 2) o_valid)
        else $error("accepted word did not produce a result on time");

    // The clamp keeps each valid bearing within a half turn; the check is built only for ANGLE_FRAC_BITS up to 16.
    if (ANGLE_FRAC_BITS <= 16) begin : g_range_chk
        a_bearing_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
            o_valid |-> (o_bearing_degrees <= $signed(OUT_W'(LIM)))
                     && (o_bearing_degrees >= -$signed(OUT_W'(LIM))))
            else $error("bearing outside plus or minus 180 degrees");
    end

endmodule
